// File: rtl/rts_pkg.sv
// ----------------------------------------------------------------------------
// rts_pkg
// Types and codes shared by the repeating timer scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rts_pkg;

   localparam int SLOTS_DEF = 16;
   localparam int MAX_FIRES = 16;
   localparam int FIRE_CW   = $clog2(MAX_FIRES + 1);

   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_CANCEL = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;

   localparam logic [2:0] KIND_ADDED     = 3'd0;
   localparam logic [2:0] KIND_FULL      = 3'd1;
   localparam logic [2:0] KIND_CANCELLED = 3'd2;
   localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
   localparam logic [2:0] KIND_FIRED     = 3'd4;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [31:0]        interval_ms;
      logic signed [15:0] repeat_count;
      logic [15:0]        event_code;
      logic [31:0]        cancel_id;
   } rts_req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] timer_id;
      logic [15:0] fired_event;
      logic        last;
   } rts_rsp_type;

   typedef struct packed {
      logic [31:0] slot_id;
      logic [31:0] due_time;
      logic [31:0] period;
      logic [15:0] repeats_left;
      logic [15:0] event_store;
   } rts_entry_type;

endpackage

`default_nettype wire

// File: rtl/repeating_timer_scheduler_unit.sv
// ----------------------------------------------------------------------------
// repeating_timer_scheduler_unit
// Timer table in a single-port-read memory; add, cancel and tick transactions.
//
//   Channel  Ports                        Direction  Carries
//   req      req_valid/req_stall/req_data in         add, cancel, tick
//   rsp      rsp_valid/rsp_stall/rsp_data out        status and firings
//
// Add goes straight to its decide state with no scan. Cancel makes one
// serial scan of the memory. Tick makes one scan per firing plus a final
// scan that finds no due timer for fewer than 16 firings, and no final scan
// at the cap of 16; each scan reads one entry per cycle through the
// memory's single read port.
// No clearing pass: of the timer table, reset clears the per-slot valid flops only.
// A stalled rsp holds the block in its decide or flush state; req is stalled
// until the current transaction has finished.
// ----------------------------------------------------------------------------
`default_nettype none

module repeating_timer_scheduler_unit #(
   parameter int SLOTS = rts_pkg::SLOTS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire rts_pkg::rts_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rts_pkg::rts_rsp_type      rsp_data
);
   import rts_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_DECIDE = 4'b0100,
      S_FLUSH  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   rts_req_type          req_ff, req_in;
   logic [31:0]          now_ff, now_in;
   logic [31:0]          idc_ff, idc_in;
   logic [SLOTS-1:0]     valid_ff, valid_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [IW-1:0]        rd_idx_ff, rd_idx_in;
   rts_entry_type        mem_q_ff;
   logic                 best_vld_ff, best_vld_in;
   logic [IW-1:0]        best_idx_ff, best_idx_in;
   logic [31:0]          best_key_ff, best_key_in;
   rts_entry_type        best_ent_ff, best_ent_in;
   logic [FIRE_CW-1:0]   fire_cnt_ff, fire_cnt_in;
   rts_rsp_type          pend_ff, pend_in;
   logic                 pend_vld_ff, pend_vld_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rts_rsp_type          rsp_data_ff, rsp_data_in;

   rts_entry_type        mem [SLOTS];
   logic                 mem_we;
   logic [IW-1:0]        mem_wa;
   rts_entry_type        mem_wd;
   logic                 rd_en;
   logic [IW-1:0]        rd_addr;

   logic                 accept;
   logic                 out_free;
   logic                 rsp_load;
   rts_rsp_type          rsp_next;
   logic [31:0]          diff;
   logic                 is_due;
   logic [31:0]          key;
   logic                 cand;
   logic                 better;
   logic                 take;
   logic                 free_found;
   logic [IW-1:0]        free_idx;
   logic [31:0]          add_iv;
   logic [15:0]          new_reps;

   assign accept    = req_valid & ~req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // scan compare on the registered read data
   assign diff   = mem_q_ff.due_time - now_ff;
   assign is_due = (diff == 32'd0) | diff[31];
   assign key    = diff ^ 32'h8000_0000;
   assign cand   = rd_vld_ff & valid_ff[rd_idx_ff] & is_due;
   assign better = ~best_vld_ff | (key < best_key_ff) |
                   ((key == best_key_ff) & (mem_q_ff.slot_id < best_ent_ff.slot_id));

   always_comb begin
      if (req_ff.req_type == REQ_TICK) begin
         take = cand & better;
      end else begin
         take = rd_vld_ff & valid_ff[rd_idx_ff] & ~best_vld_ff &
                (mem_q_ff.slot_id == req_ff.cancel_id);
      end
   end

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IW'(i);
         end
      end
   end

   assign add_iv   = (req_ff.interval_ms == 32'd0) ? 32'd1 : req_ff.interval_ms;
   assign new_reps = ((best_ent_ff.repeats_left != 16'd0) && !best_ent_ff.repeats_left[15]) ?
                     best_ent_ff.repeats_left - 16'd1 : best_ent_ff.repeats_left;

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      now_in      = now_ff;
      idc_in      = idc_ff;
      valid_in    = valid_ff;
      cnt_in      = cnt_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = cnt_ff[IW-1:0];
      rd_en       = 1'b0;
      rd_addr     = cnt_ff[IW-1:0];
      best_vld_in = best_vld_ff;
      best_idx_in = best_idx_ff;
      best_key_in = best_key_ff;
      best_ent_in = best_ent_ff;
      fire_cnt_in = fire_cnt_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      mem_we      = 1'b0;
      mem_wa      = best_idx_ff;
      mem_wd      = best_ent_ff;
      rsp_load    = 1'b0;
      rsp_next    = pend_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in      = req_data;
               cnt_in      = '0;
               best_vld_in = 1'b0;
               unique case (req_data.req_type)
                  REQ_ADD: begin
                     state_in = S_DECIDE;
                  end
                  REQ_CANCEL: begin
                     state_in = S_SCAN;
                  end
                  REQ_TICK: begin
                     now_in      = now_ff + 32'd1;
                     fire_cnt_in = '0;
                     pend_vld_in = 1'b0;
                     state_in    = S_SCAN;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (cnt_ff < CW'(SLOTS)) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + CW'(1);
            end
            if (take) begin
               best_vld_in = 1'b1;
               best_idx_in = rd_idx_ff;
               best_key_in = key;
               best_ent_in = mem_q_ff;
            end
            if ((cnt_ff == CW'(SLOTS)) && !rd_vld_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (out_free) begin
               state_in = S_IDLE;
               unique case (req_ff.req_type)
                  REQ_ADD: begin
                     rsp_load = 1'b1;
                     if (free_found) begin
                        mem_we              = 1'b1;
                        mem_wa              = free_idx;
                        mem_wd.slot_id      = idc_ff + 32'd1;
                        mem_wd.due_time     = now_ff + add_iv;
                        mem_wd.period       = add_iv;
                        mem_wd.repeats_left = req_ff.repeat_count;
                        mem_wd.event_store  = req_ff.event_code;
                        valid_in[free_idx]  = 1'b1;
                        idc_in              = idc_ff + 32'd1;
                        rsp_next            = '{KIND_ADDED, idc_ff + 32'd1, 16'd0, 1'b1};
                     end else begin
                        rsp_next = '{KIND_FULL, 32'd0, 16'd0, 1'b1};
                     end
                  end
                  REQ_CANCEL: begin
                     rsp_load = 1'b1;
                     if (best_vld_ff) begin
                        valid_in[best_idx_ff] = 1'b0;
                        rsp_next = '{KIND_CANCELLED, req_ff.cancel_id, 16'd0, 1'b1};
                     end else begin
                        rsp_next = '{KIND_NOT_FOUND, req_ff.cancel_id, 16'd0, 1'b1};
                     end
                  end
                  REQ_TICK: begin
                     if (best_vld_ff) begin
                        mem_we              = 1'b1;
                        mem_wa              = best_idx_ff;
                        mem_wd.due_time     = best_ent_ff.due_time + best_ent_ff.period;
                        mem_wd.repeats_left = new_reps;
                        if (new_reps == 16'd0) begin
                           valid_in[best_idx_ff] = 1'b0;
                        end
                        if (pend_vld_ff) begin
                           rsp_load      = 1'b1;
                           rsp_next      = pend_ff;
                           rsp_next.last = 1'b0;
                        end
                        pend_in     = '{KIND_FIRED, best_ent_ff.slot_id,
                                        best_ent_ff.event_store, 1'b0};
                        pend_vld_in = 1'b1;
                        fire_cnt_in = fire_cnt_ff + FIRE_CW'(1);
                        cnt_in      = '0;
                        best_vld_in = 1'b0;
                        if (fire_cnt_in == FIRE_CW'(MAX_FIRES)) begin
                           state_in = S_FLUSH;
                        end else begin
                           state_in = S_SCAN;
                        end
                     end else if (pend_vld_ff) begin
                        rsp_load      = 1'b1;
                        rsp_next      = pend_ff;
                        rsp_next.last = 1'b1;
                        pend_vld_in   = 1'b0;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_next      = pend_ff;
               rsp_next.last = 1'b1;
               pend_vld_in   = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_data_in  = rsp_load ? rsp_next : rsp_data_ff;
      rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);
   end

   // timer table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         now_ff       <= '0;
         idc_ff       <= '0;
         valid_ff     <= '0;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         best_vld_ff  <= 1'b0;
         fire_cnt_ff  <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         idc_ff       <= idc_in;
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         best_vld_ff  <= best_vld_in;
         fire_cnt_ff  <= fire_cnt_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rd_idx_ff   <= rd_idx_in;
      best_idx_ff <= best_idx_in;
      best_key_ff <= best_key_in;
      best_ent_ff <= best_ent_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_fire_cap: assert property (@(posedge clock) disable iff (reset)
      fire_cnt_ff <= FIRE_CW'(MAX_FIRES))
      else $error("firing count above cap");

   a_pend_tick: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> (req_ff.req_type == REQ_TICK))
      else $error("pending firing outside a tick");

   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH && out_free) |=> (rsp_valid && rsp_data.last))
      else $error("flush did not deliver a final firing");

   a_best_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && req_ff.req_type == REQ_TICK && best_vld_ff)
      |-> valid_ff[best_idx_ff])
      else $error("selected timer slot is not live");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == S_SCAN))
      else $error("read data outside a scan");

endmodule

`default_nettype wire
